// ===== sv/eht_pkg.sv =====
// Package for the extendible hash table core: payload structs, status codes,
// operation codes and default sizes. No dependencies.
package eht_pkg;

    localparam int KEY_BITS_DEF     = 18;
    localparam int BUCKET_SLOTS_DEF = 4;
    localparam int MAX_DEPTH_DEF    = 10;
    localparam int NUM_BUCKETS_DEF  = 1024;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_FIND   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [17:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [17:0] result_key;
    } rsp_t;

endpackage

// ===== sv/eht_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module eht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/extendible_hash_table_core.sv =====
// Extendible hash set core: one operation per input beat, one result beat each.
// A remove also shifts the later keys of its bucket down; an insert into a full bucket splits it,
// first doubling the directory when the bucket's local depth has reached the global depth.
// One item at a time; a finished result waits in an output register while the next is taken.
// Reset: a clearing pass writes every directory entry, one per cycle.
module extendible_hash_table_core #(
    parameter int KEY_BITS     = eht_pkg::KEY_BITS_DEF,
    parameter int BUCKET_SLOTS = eht_pkg::BUCKET_SLOTS_DEF,
    parameter int MAX_DEPTH    = eht_pkg::MAX_DEPTH_DEF,
    parameter int NUM_BUCKETS  = eht_pkg::NUM_BUCKETS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  eht_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output eht_pkg::rsp_t out_data
);
    localparam int DIRN  = 1 << MAX_DEPTH;
    localparam int DAW   = MAX_DEPTH;
    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int SW    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int FW    = $clog2(BUCKET_SLOTS + 1);
    localparam int DW    = $clog2(MAX_DEPTH + 2);
    localparam int LIM   = (MAX_DEPTH < KEY_BITS) ? MAX_DEPTH : KEY_BITS;
    localparam int KAW   = BW + SW;
    localparam int PW    = BW + 1;
    localparam int IW    = DAW + 1;
    localparam int KPW   = $clog2(KEY_BITS);

    // State codes.
    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DIR   = 5'd2;
    localparam logic [4:0] S_INFO  = 5'd3;
    localparam logic [4:0] S_SCAN  = 5'd4;
    localparam logic [4:0] S_SCANW = 5'd5;
    localparam logic [4:0] S_DEC   = 5'd6;
    localparam logic [4:0] S_SHIFT = 5'd7;
    localparam logic [4:0] S_SHW   = 5'd8;
    localparam logic [4:0] S_DBLR  = 5'd9;
    localparam logic [4:0] S_DBLW  = 5'd10;
    localparam logic [4:0] S_DBLW2 = 5'd11;
    localparam logic [4:0] S_SPR   = 5'd12;
    localparam logic [4:0] S_SPW   = 5'd13;
    localparam logic [4:0] S_SPINF = 5'd14;
    localparam logic [4:0] S_SDR   = 5'd15;
    localparam logic [4:0] S_SDW   = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;
    localparam logic [4:0] S_SDWT  = 5'd18;

    logic [4:0] st_reg, st_next;

    // Memories: directory, bucket info (fill + local depth), bucket keys.
    logic           dir_we;
    logic [DAW-1:0] dir_addr;
    logic [BW-1:0]  dir_wd, dir_rd;
    logic           inf_we;
    logic [BW-1:0]  inf_addr;
    logic [FW+DW-1:0] inf_wd, inf_rd;
    logic           key_we;
    logic [KAW-1:0] key_addr;
    logic [KEY_BITS-1:0] key_wd, key_rd;

    eht_ram #(.WIDTH(BW), .DEPTH(DIRN)) u_dir (
        .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wd), .rdata(dir_rd));
    eht_ram #(.WIDTH(FW + DW), .DEPTH(NUM_BUCKETS)) u_inf (
        .clk(clk), .we(inf_we), .addr(inf_addr), .wdata(inf_wd), .rdata(inf_rd));
    eht_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_BUCKETS * (1 << SW))) u_key (
        .clk(clk), .we(key_we), .addr(key_addr), .wdata(key_wd), .rdata(key_rd));

    logic [1:0]          fn_reg, fn_next;
    logic [KEY_BITS-1:0] k_reg, k_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [DW-1:0]       ld_reg, ld_next;
    logic [DW-1:0]       gd_reg, gd_next;
    logic [PW-1:0]       nfb_reg, nfb_next;
    logic [FW-1:0]       i_reg, i_next;
    logic [FW-1:0]       keep_reg, keep_next;
    logic [FW-1:0]       nf_reg, nf_next;
    logic [IW-1:0]       d_reg, d_next;
    logic [BW-1:0]       hold_reg, hold_next;
    logic [SW:0]         hit_reg, hit_next;
    logic                found_reg, found_next;
    logic                ov_reg, ov_next;
    eht_pkg::rsp_t       od_reg, od_next;
    eht_pkg::rsp_t       res_reg, res_next;

    // Directory index: the top gd bits of the key.
    function automatic logic [DAW-1:0] dir_idx(input logic [KEY_BITS-1:0] k,
                                               input logic [DW-1:0] gd);
        logic [KEY_BITS+DAW-1:0] w;
        begin
            w = {{DAW{1'b0}}, k} << gd;
            dir_idx = w[KEY_BITS+DAW-1:KEY_BITS];
        end
    endfunction

    function automatic logic [SW-1:0] i_next_slot(input logic [FW-1:0] i);
        logic [FW-1:0] n;
        begin
            n = i + 1'b1;
            i_next_slot = n[SW-1:0];
        end
    endfunction

    logic [DW-1:0]  nl;
    logic [KPW-1:0] kpos;
    logic           kbit;
    logic [IW-1:0]  dsize;
    logic [DAW-1:0] d_lo;
    logic [DW-1:0]  dbit;
    logic           ibit;

    // A split sends a key to the new bucket when its bit KEY_BITS-nl is set; that is
    // the same bit as bit gd-nl of the directory index.
    always_comb
    begin
        nl    = ld_reg + 1'b1;
        kpos  = KPW'(KEY_BITS - int'(nl));
        kbit  = key_rd[kpos];
        dsize = IW'(1) << gd_reg;
        d_lo  = d_reg[DAW-1:0];
        dbit  = gd_reg - nl;
        ibit  = d_lo[dbit[$clog2(DAW+1)-1:0]];
    end

    // The result of the last item sits in the output register, so the next item can
    // be taken while it waits; it only has to wait in S_DONE for the register to free.
    assign in_stall  = (st_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        st_next = st_reg; fn_next = fn_reg; k_next = k_reg; b_next = b_reg;
        fill_next = fill_reg; ld_next = ld_reg; gd_next = gd_reg; nfb_next = nfb_reg;
        i_next = i_reg; keep_next = keep_reg; nf_next = nf_reg; d_next = d_reg;
        hold_next = hold_reg; hit_next = hit_reg; found_next = found_reg;
        ov_next = ov_reg; od_next = od_reg; res_next = res_reg;
        dir_we = 1'b0; dir_addr = dir_idx(k_reg, gd_reg); dir_wd = b_reg;
        inf_we = 1'b0; inf_addr = b_reg; inf_wd = {fill_reg, ld_reg};
        key_we = 1'b0; key_addr = {b_reg, i_reg[SW-1:0]}; key_wd = k_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_CLR:
            begin
                dir_we = 1'b1; dir_addr = d_lo; dir_wd = '0;
                inf_we = (d_reg == '0); inf_addr = '0; inf_wd = '0;
                d_next = d_reg + 1'b1;
                if (d_reg == IW'(DIRN - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    fn_next = in_data.func;
                    k_next  = in_data.key[KEY_BITS-1:0];
                    dir_addr = dir_idx(in_data.key[KEY_BITS-1:0], gd_reg);
                    st_next = S_DIR;
                end
            end
            S_DIR:
            begin
                b_next = dir_rd; inf_addr = dir_rd; st_next = S_INFO;
            end
            S_INFO:
            begin
                fill_next = inf_rd[FW+DW-1:DW]; ld_next = inf_rd[DW-1:0];
                i_next = '0; found_next = 1'b0; st_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (found_reg || i_reg >= fill_reg)
                begin
                    st_next = S_DEC;
                end
                else
                begin
                    st_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (key_rd == k_reg)
                begin
                    found_next = 1'b1; hit_next = (SW+1)'(i_reg);
                end
                i_next = i_reg + 1'b1; st_next = S_SCAN;
            end
            S_DEC:
            begin
                st_next = S_DONE;
                res_next.result_key = '0;
                if (fn_reg == eht_pkg::FN_FIND)
                begin
                    res_next.status = found_reg ? eht_pkg::ST_FOUND : eht_pkg::ST_NOT_FOUND;
                    if (found_reg)
                    begin
                        res_next.result_key = 18'(k_reg);
                    end
                end
                else if (fn_reg == eht_pkg::FN_REMOVE)
                begin
                    res_next.status = found_reg ? eht_pkg::ST_REMOVED : eht_pkg::ST_NOT_FOUND;
                    if (found_reg)
                    begin
                        i_next = FW'(hit_reg); st_next = S_SHIFT;
                    end
                end
                else if (fn_reg == eht_pkg::FN_INSERT)
                begin
                    if (found_reg)
                    begin
                        res_next.status = eht_pkg::ST_DUPLICATE;
                    end
                    else if (fill_reg < FW'(BUCKET_SLOTS))
                    begin
                        res_next.status = eht_pkg::ST_INSERTED;
                        key_we = 1'b1; key_addr = {b_reg, fill_reg[SW-1:0]};
                        inf_we = 1'b1; inf_wd = {fill_reg + 1'b1, ld_reg};
                    end
                    else if (ld_reg >= DW'(LIM) || nfb_reg >= PW'(NUM_BUCKETS))
                    begin
                        res_next.status = eht_pkg::ST_FULL;
                    end
                    else if (ld_reg >= gd_reg)
                    begin
                        d_next = dsize - 1'b1; st_next = S_DBLR;
                    end
                    else
                    begin
                        i_next = '0; keep_next = '0; nf_next = '0; st_next = S_SPR;
                    end
                end
                else
                begin
                    res_next.status = eht_pkg::ST_NOT_FOUND;
                end
            end
            S_SHIFT:
            begin
                if (i_reg + 1'b1 >= fill_reg)
                begin
                    inf_we = 1'b1; inf_wd = {fill_reg - 1'b1, ld_reg};
                    st_next = S_DONE;
                end
                else
                begin
                    key_addr = {b_reg, i_next_slot(i_reg)}; st_next = S_SHW;
                end
            end
            S_SHW:
            begin
                key_we = 1'b1; key_wd = key_rd; i_next = i_reg + 1'b1;
                st_next = S_SHIFT;
            end
            S_DBLR:
            begin
                dir_addr = d_lo; st_next = S_DBLW;
            end
            S_DBLW:
            begin
                hold_next = dir_rd;
                dir_we = 1'b1; dir_addr = {d_lo[DAW-2:0], 1'b1}; dir_wd = dir_rd;
                st_next = S_DBLW2;
            end
            S_DBLW2:
            begin
                dir_we = 1'b1; dir_addr = {d_lo[DAW-2:0], 1'b0}; dir_wd = hold_reg;
                if (d_reg == '0)
                begin
                    gd_next = gd_reg + 1'b1;
                    i_next = '0; keep_next = '0; nf_next = '0; st_next = S_SPR;
                end
                else
                begin
                    d_next = d_reg - 1'b1; st_next = S_DBLR;
                end
            end
            S_SPR:
            begin
                if (i_reg >= fill_reg)
                begin
                    inf_we = 1'b1; inf_wd = {keep_reg, nl};
                    st_next = S_SPINF;
                end
                else
                begin
                    st_next = S_SPW;
                end
            end
            S_SPW:
            begin
                key_we = 1'b1; key_wd = key_rd;
                if (kbit)
                begin
                    key_addr = {nfb_reg[BW-1:0], nf_reg[SW-1:0]}; nf_next = nf_reg + 1'b1;
                end
                else
                begin
                    key_addr = {b_reg, keep_reg[SW-1:0]}; keep_next = keep_reg + 1'b1;
                end
                i_next = i_reg + 1'b1; st_next = S_SPR;
            end
            S_SPINF:
            begin
                inf_we = 1'b1; inf_addr = nfb_reg[BW-1:0]; inf_wd = {nf_reg, nl};
                d_next = '0; st_next = S_SDR;
            end
            S_SDR:
            begin
                dir_addr = d_lo; st_next = S_SDW;
            end
            S_SDW:
            begin
                dir_addr = d_lo;
                if (dir_rd == b_reg && ibit)
                begin
                    dir_we = 1'b1; dir_wd = nfb_reg[BW-1:0];
                end
                st_next = S_SDWT;
            end
            S_SDWT:
            begin
                if (d_reg + 1'b1 >= dsize)
                begin
                    nfb_next = nfb_reg + 1'b1;
                    dir_addr = dir_idx(k_reg, gd_reg); st_next = S_DIR;
                end
                else
                begin
                    d_next = d_reg + 1'b1; st_next = S_SDR;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1; od_next = res_reg; st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR; gd_reg <= '0; nfb_reg <= PW'(1); ov_reg <= 1'b0;
            d_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; gd_reg <= gd_next; nfb_reg <= nfb_next;
            ov_reg <= ov_next; d_reg <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fn_reg <= fn_next; k_reg <= k_next; b_reg <= b_next; fill_reg <= fill_next;
        ld_reg <= ld_next; i_reg <= i_next; keep_reg <= keep_next; nf_reg <= nf_next;
        hold_reg <= hold_next; hit_reg <= hit_next; found_reg <= found_next;
        od_reg <= od_next; res_reg <= res_next;
    end
endmodule

// ===== sv/eht_checker.sv =====
// Port-level checker for the extendible hash table core, bound to the top level.
// Depends on eht_pkg.
module eht_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input eht_pkg::rsp_t out_data,
    input logic          out_valid,
    input logic          out_stall
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= eht_pkg::ST_FULL)
        else $error("bad status");
    a_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != eht_pkg::ST_FOUND |-> out_data.result_key == '0)
        else $error("key echoed without found");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while busy");
endmodule

bind extendible_hash_table_core eht_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall));

// ===== tb/tb_extendible_hash_table_core.sv =====
`timescale 1ns / 100ps
// Testbench for the extendible hash set core: directed and random insert, remove
// and find beats checked against an internal model. Depends on eht_pkg and the core.
module tb_extendible_hash_table_core;

    localparam int KB = eht_pkg::KEY_BITS_DEF;
    localparam int SLOTS = eht_pkg::BUCKET_SLOTS_DEF;
    localparam int MAXD = eht_pkg::MAX_DEPTH_DEF;
    localparam int NBKT = eht_pkg::NUM_BUCKETS_DEF;
    localparam int DLIM = (MAXD < KB) ? MAXD : KB;
    localparam int LIMIT_CYCLES = 20000000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    eht_pkg::req_t  in_data;
    logic           out_valid;
    logic           out_stall;
    eht_pkg::rsp_t  out_data;

    extendible_hash_table_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // The model of the hash set: directory, bucket pool and depths.
    int unsigned dir_tbl [0:(1<<MAXD)-1];
    logic [17:0] slot_key [0:NBKT-1][0:SLOTS-1];
    int unsigned fill_cnt [0:NBKT-1];
    int unsigned ldepth [0:NBKT-1];
    int unsigned gdepth;
    int unsigned free_bkt;

    eht_pkg::rsp_t resp_fifo [$];
    int unsigned mismatches;
    int unsigned results_seen;
    longint unsigned cycle_cnt;
    int unsigned hold_cycles;   // when nonzero, sets the length of the receiver's next stall
    bit random_idle;
    logic [17:0] live_keys [$];

    function automatic int unsigned bucket_of(logic [17:0] k);
        if (gdepth == 0)
            return dir_tbl[0];
        return dir_tbl[k >> (KB - gdepth)];
    endfunction

    function automatic int find_slot(int unsigned b, logic [17:0] k);
        for (int i = 0; i < fill_cnt[b] && i < SLOTS; i++)
            if (slot_key[b][i] == k)
                return i;
        return -1;
    endfunction

    function automatic void grow_directory();
        for (int i = (1 << gdepth) - 1; i >= 0; i--)
        begin
            dir_tbl[2*i+1] = dir_tbl[i];
            dir_tbl[2*i] = dir_tbl[i];
        end
        gdepth++;
    endfunction

    function automatic void split_one(int unsigned b);
        int unsigned nb;
        int unsigned nl;
        int unsigned keep;
        logic [17:0] k;
        nb = free_bkt;
        nl = ldepth[b] + 1;
        keep = 0;
        free_bkt++;
        fill_cnt[nb] = 0;
        ldepth[nb] = nl;
        ldepth[b] = nl;
        for (int i = 0; i < fill_cnt[b] && i < SLOTS; i++)
        begin
            k = slot_key[b][i];
            if (k[KB - nl])
            begin
                slot_key[nb][fill_cnt[nb]] = k;
                fill_cnt[nb]++;
            end
            else
            begin
                slot_key[b][keep] = k;
                keep++;
            end
        end
        fill_cnt[b] = keep;
        for (int i = 0; i < (1 << gdepth); i++)
            if (dir_tbl[i] == b && ((i >> (gdepth - nl)) & 1))
                dir_tbl[i] = nb;
    endfunction

    // Applies one operation to the model and returns the expected result.
    function automatic eht_pkg::rsp_t hash_set_apply(eht_pkg::req_t r);
        eht_pkg::rsp_t rs;
        int unsigned b;
        int s;
        rs.status = eht_pkg::ST_NOT_FOUND;
        rs.result_key = '0;
        if (r.func == eht_pkg::FN_INSERT)
        begin
            forever
            begin
                b = bucket_of(r.key);
                if (find_slot(b, r.key) >= 0)
                begin
                    rs.status = eht_pkg::ST_DUPLICATE;
                    break;
                end
                if (fill_cnt[b] < SLOTS)
                begin
                    slot_key[b][fill_cnt[b]] = r.key;
                    fill_cnt[b]++;
                    rs.status = eht_pkg::ST_INSERTED;
                    break;
                end
                if (ldepth[b] >= DLIM || free_bkt >= NBKT)
                begin
                    rs.status = eht_pkg::ST_FULL;
                    break;
                end
                if (ldepth[b] >= gdepth)
                    grow_directory();
                split_one(b);
            end
        end
        else if (r.func == eht_pkg::FN_REMOVE)
        begin
            b = bucket_of(r.key);
            s = find_slot(b, r.key);
            if (s >= 0)
            begin
                for (int i = s; i + 1 < fill_cnt[b]; i++)
                    slot_key[b][i] = slot_key[b][i+1];
                fill_cnt[b]--;
                rs.status = eht_pkg::ST_REMOVED;
            end
        end
        else if (r.func == eht_pkg::FN_FIND)
        begin
            if (find_slot(bucket_of(r.key), r.key) >= 0)
            begin
                rs.status = eht_pkg::ST_FOUND;
                rs.result_key = r.key;
            end
        end
        return rs;
    endfunction

    // Sends one beat after a gap, random when random_idle is set; the expectation is queued at acceptance.
    // Valid drops only when a gap follows, so back-to-back beats keep it high.
    task automatic send_op(logic [1:0] f, logic [17:0] k);
        eht_pkg::req_t r;
        int gap;
        r.func = f;
        r.key = k;
        gap = random_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        resp_fifo.push_back(hash_set_apply(r));
        if (f == eht_pkg::FN_INSERT)
            live_keys.push_back(k);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (resp_fifo.size() != 0)
            @(negedge clk);
    endtask

    // Receiver stall: random per result, or a long hold when requested.
    initial
    begin
        int w;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
            w = random_idle ? $urandom_range(0, 9) : 0;
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w - 1) @(negedge clk);
            end
        end
    end

    // Result checker: compares every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        eht_pkg::rsp_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (resp_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat status=%0d key=%0h",
                             out_data.status, out_data.result_key);
            end
            else
            begin
                exp_r = resp_fifo.pop_front();
                if (out_data.status !== exp_r.status
                    || out_data.result_key !== exp_r.result_key)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d key=%0h, got status=%0d key=%0h",
                                 exp_r.status, exp_r.result_key,
                                 out_data.status, out_data.result_key);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [17:0] pick_key();
        if (live_keys.size() != 0 && $urandom_range(0, 2) != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return 18'($urandom);
    endfunction

    // Extremes of the key, every operation, duplicates and absent keys.
    task automatic test_directed();
        send_op(eht_pkg::FN_FIND, 18'h0);
        send_op(eht_pkg::FN_REMOVE, 18'h0);
        send_op(eht_pkg::FN_INSERT, 18'h0);
        send_op(eht_pkg::FN_INSERT, 18'h3FFFF);
        send_op(eht_pkg::FN_INSERT, 18'h0);
        send_op(eht_pkg::FN_FIND, 18'h3FFFF);
        send_op(eht_pkg::FN_FIND, 18'h2AAAA);
        send_op(2'd3, 18'h15555);
        send_op(eht_pkg::FN_INSERT, 18'h15555);
        send_op(eht_pkg::FN_INSERT, 18'h2AAAA);
        // Bucket zero is now full; a duplicate must not split it.
        send_op(eht_pkg::FN_INSERT, 18'h15555);
        send_op(eht_pkg::FN_INSERT, 18'h00001);
        send_op(eht_pkg::FN_REMOVE, 18'h3FFFF);
        send_op(eht_pkg::FN_REMOVE, 18'h3FFFF);
        send_op(eht_pkg::FN_FIND, 18'h00001);
        send_op(eht_pkg::FN_FIND, 18'h3FFFF);
    endtask

    // Keys sharing their top ten bits force splits to the depth limit: table full.
    task automatic test_depth_limit();
        for (int i = 0; i < 7; i++)
            send_op(eht_pkg::FN_INSERT, {10'h3C5, 8'(i * 37)});
        send_op(eht_pkg::FN_FIND, {10'h3C5, 8'd37});
        send_op(eht_pkg::FN_REMOVE, {10'h3C5, 8'd0});
        send_op(eht_pkg::FN_INSERT, {10'h3C5, 8'd255});
    endtask

    // Long receiver hold while the sender keeps offering beats.
    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_op(2'($urandom_range(0, 2)), pick_key());
        wait_drained();
    endtask

    // Mostly inserts of random and clustered keys.
    task automatic test_random(int n, bit clustered);
        logic [1:0] f;
        logic [17:0] k;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: f = eht_pkg::FN_INSERT;
                5, 6:          f = eht_pkg::FN_FIND;
                7, 8:          f = eht_pkg::FN_REMOVE;
                default:       f = 2'($urandom);
            endcase
            k = pick_key();
            if (clustered && f == eht_pkg::FN_INSERT)
                k[17:12] = 6'($urandom_range(0, 3));
            send_op(f, k);
            if ($urandom_range(0, 49) == 0)
                random_idle = !random_idle;
        end
    endtask

    initial
    begin
        for (int i = 0; i < (1 << MAXD); i++)
            dir_tbl[i] = 0;
        for (int i = 0; i < NBKT; i++)
        begin
            fill_cnt[i] = 0;
            ldepth[i] = 0;
        end
        gdepth = 0;
        free_bkt = 1;
        mismatches = 0;
        results_seen = 0;
        cycle_cnt = 0;
        hold_cycles = 0;
        random_idle = 1'b1;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_depth_limit();
        test_backpressure();
        test_random(300, 1'b0);
        wait_drained();
        test_random(420, 1'b1);
        wait_drained();
        random_idle = 1'b1;
        repeat (200) @(negedge clk);

        $display("Covered %0d results; directory depth reached %0d, %0d buckets used.",
                 results_seen, gdepth, free_bkt);
        if (mismatches == 0 && resp_fifo.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
